// File: src/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, constants and saturation helper for the escape-time engine
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;

    localparam int COL_W   = $clog2(FRAME_WIDTH);
    localparam int ROW_W   = $clog2(FRAME_HEIGHT);
    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 8;
    localparam int HUE_W   = 8;

    // products of index and step
    localparam int PRODR_W = COL_W + STEP_W;
    localparam int PRODI_W = ROW_W + STEP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0] pixel_col;
        logic [ROW_W-1:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic [COL_W-1:0]   out_col;
        logic [ROW_W-1:0]   out_row;
        logic [LIMIT_W-1:0] pass_count;
        logic               inside_res;
        logic [HUE_W-1:0]   hue;
    } pix_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_real;
        logic signed [COORD_W-1:0] origin_imag;
        logic [STEP_W-1:0]         step_real;
        logic [STEP_W-1:0]         step_imag;
        logic [LIMIT_W-1:0]        iteration_limit;
        logic [STEP_W-1:0]         escape_limit;
    } cfg_t;

    // point handed from front to back
    typedef struct packed {
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
    } point_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } q_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // clamp to the signed 32 bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// escape-time engine: pixel index in, pass count, inside flag and hue out
// ----------------------------------------------------------------------------
// usage
//   pixel channel: valid/ready, one item per pixel (column, row)
//   result channel: valid/ready, one item per pixel, in input order
//   cfg port: write enable, index and data; change registers only while idle
// flow
//   front: index times step is registered in F_MUL after accept; the origin
//   is added and the point queued in F_PUSH once the queue has room; no new
//   pixel is taken until that point is queued
//   back: pop in S_IDLE, then loops of S_MUL (multiply) and S_UPD (test and
//   update; an escaped point runs one loop more than its pass count), then a
//   bit-serial restoring hue divide of the 16-bit n*255 in S_DIV, and S_DONE
//   into the output register; the back takes the next point only after that
//   and sets the rate of the engine
// reset
//   clears both state machines, the queue and the output valid;
//   registers return to their default view of the plane
// stall
//   a result waits in the output register; the back stops in its last state,
//   the queue fills and then the front stops taking pixels
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pix_in_t               pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pix_out_t              result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    cfg_t    cfg_reg, cfg_next;

    // queue between front and back
    q_req_t  q_req;
    q_stat_t q_stat;
    point_t  q_wr_data;
    point_t  q_rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ORIGIN_REAL: cfg_next.origin_real     = cfg_data;
                REG_ORIGIN_IMAG: cfg_next.origin_imag     = cfg_data;
                REG_STEP_REAL:   cfg_next.step_real       = cfg_data[STEP_W-1:0];
                REG_STEP_IMAG:   cfg_next.step_imag       = cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT:  cfg_next.iteration_limit = cfg_data[LIMIT_W-1:0];
                REG_ESC_LIMIT:   cfg_next.escape_limit    = cfg_data[STEP_W-1:0];
                default:         cfg_next                 = cfg_reg; // unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_real     <= -32'sd68249547;
            cfg_reg.origin_imag     <= -32'sd45446122;
            cfg_reg.step_real       <= 31'd1638400;
            cfg_reg.step_imag       <= 31'd1638400;
            cfg_reg.iteration_limit <= 8'd15;
            cfg_reg.escape_limit    <= 31'd268435456;   // 16.0 in q8.24
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept pixel, form c
    mbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .q_stat      (q_stat),
        .q_push      (q_req.push),
        .q_data      (q_wr_data)
    );

    mbe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (q_req),
        .wr_data (q_wr_data),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // back: iterate, divide for hue, present result
    mbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .q_data       (q_rd_data),
        .q_pop        (q_req.pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: src/mbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_queue
// short point queue between front and back
// ----------------------------------------------------------------------------
module mbe_queue
    import mbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_req_t  req,
    input  point_t  wr_data,
    output point_t  rd_data,
    output q_stat_t stat
);

    point_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = req.push && !stat.full;
    assign do_pop     = req.pop && !stat.empty;
    assign rd_data    = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/mbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_front
// takes pixel items and maps them to the point c in the plane
// ----------------------------------------------------------------------------
module mbe_front
    import mbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    pixel_valid,
    output logic    pixel_ready,
    input  pix_in_t pixel,
    input  q_stat_t q_stat,
    output logic    q_push,
    output point_t  q_data
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} state_t;

    state_t               state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [PRODR_W-1:0]   pr_reg, pr_next;
    logic [PRODI_W-1:0]   pi_reg, pi_next;
    logic signed [PRODR_W+1:0] sum_r;
    logic signed [PRODI_W+1:0] sum_i;

    assign pixel_ready = (state_reg == F_IDLE);

    // origin plus index times step, then clamp
    assign sum_r = $signed({2'b00, pr_reg}) + (PRODR_W+2)'(cfg.origin_real);
    assign sum_i = $signed({2'b00, pi_reg}) + (PRODI_W+2)'(cfg.origin_imag);

    assign q_data.col = col_reg;
    assign q_data.row = row_reg;
    assign q_data.cr  = sat32(64'(sum_r));
    assign q_data.ci  = sat32(64'(sum_i));
    assign q_push     = (state_reg == F_PUSH) && !q_stat.full;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pr_next    = pr_reg;
        pi_next    = pi_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (pixel_valid)
                begin
                    col_next   = pixel.pixel_col;
                    row_next   = pixel.pixel_row;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                pr_next    = PRODR_W'(col_reg) * PRODR_W'(cfg.step_real);
                pi_next    = PRODI_W'(row_reg) * PRODI_W'(cfg.step_imag);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pr_reg    <= '0;
            pi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pr_reg    <= pr_next;
            pi_reg    <= pi_next;
        end
    end

endmodule

// File: src/mbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_back
// runs the escape iteration, derives the hue and holds the result item
// ----------------------------------------------------------------------------
module mbe_back
    import mbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  q_stat_t  q_stat,
    input  point_t   q_data,
    output logic     q_pop,
    output logic     result_valid,
    input  logic     result_ready,
    output pix_out_t result
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_UPD, S_DIV, S_DONE} state_t;

    localparam int DIVD_W = 2 * LIMIT_W;
    localparam int CNT_W  = $clog2(DIVD_W);

    state_t                    state_reg, state_next;
    logic signed [COORD_W-1:0] a_reg, a_next;
    logic signed [COORD_W-1:0] b_reg, b_next;
    logic signed [COORD_W-1:0] cr_reg, cr_next;
    logic signed [COORD_W-1:0] ci_reg, ci_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [LIMIT_W-1:0]        n_reg, n_next;
    logic signed [63:0]        aa_p_reg, aa_p_next;
    logic signed [63:0]        bb_p_reg, bb_p_next;
    logic signed [63:0]        ab_p_reg, ab_p_next;
    logic [DIVD_W-1:0]         q_reg, q_next;
    logic [LIMIT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    pix_out_t                  out_reg, out_next;

    logic signed [COORD_W-1:0] aa, bb, tab, len;
    logic signed [COORD_W+1:0] len_sum;
    logic                      escaped;
    logic [LIMIT_W-1:0]        n_inc;
    logic [LIMIT_W:0]          trial;
    logic                      trial_ge;

    // n*255 as the divider's dividend
    function automatic logic [DIVD_W-1:0] hue_dividend(input logic [LIMIT_W-1:0] n);
        return {n, LIMIT_W'(0)} - DIVD_W'(n);
    endfunction

    // floor shifts of the registered products
    assign aa  = sat32(aa_p_reg >>> 24);
    assign bb  = sat32(bb_p_reg >>> 24);
    assign tab = sat32(ab_p_reg >>> 23);

    assign len_sum = (COORD_W+2)'(aa) + (COORD_W+2)'(bb);
    assign len     = sat32(64'(len_sum));
    assign escaped = (33'(len) > $signed({2'b00, cfg.escape_limit}));
    assign n_inc   = n_reg + 1'b1;

    // one restoring step of the hue divide
    assign trial    = {rem_reg, q_reg[DIVD_W-1]};
    assign trial_ge = (trial >= {1'b0, cfg.iteration_limit});

    assign q_pop        = (state_reg == S_IDLE) && !q_stat.empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        aa_p_next      = aa_p_reg;
        bb_p_next      = bb_p_reg;
        ab_p_next      = ab_p_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    a_next   = q_data.cr;
                    b_next   = q_data.ci;
                    cr_next  = q_data.cr;
                    ci_next  = q_data.ci;
                    col_next = q_data.col;
                    row_next = q_data.row;
                    n_next   = '0;
                    rem_next = '0;
                    cnt_next = '0;
                    q_next   = '0;
                    if (cfg.iteration_limit == '0)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                aa_p_next  = 64'(a_reg) * 64'(a_reg);
                bb_p_next  = 64'(b_reg) * 64'(b_reg);
                ab_p_next  = 64'(a_reg) * 64'(b_reg);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (escaped)
                begin
                    q_next     = hue_dividend(n_reg);
                    state_next = S_DIV;
                end
                else
                begin
                    a_next = sat32(64'((COORD_W+2)'(aa) - (COORD_W+2)'(bb)
                                       + (COORD_W+2)'(cr_reg)));
                    b_next = sat32(64'((COORD_W+2)'(tab) + (COORD_W+2)'(ci_reg)));
                    n_next = n_inc;
                    if (n_inc == cfg.iteration_limit)
                    begin
                        q_next     = hue_dividend(n_inc);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = trial_ge ? LIMIT_W'(trial - {1'b0, cfg.iteration_limit})
                                    : LIMIT_W'(trial);
                q_next   = {q_reg[DIVD_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVD_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.out_col    = col_reg;
                    out_next.out_row    = row_reg;
                    out_next.pass_count = n_reg;
                    out_next.inside_res = (n_reg == cfg.iteration_limit);
                    out_next.hue        = (cfg.iteration_limit == '0) ? '0
                                                                      : q_reg[HUE_W-1:0];
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            cr_reg        <= '0;
            ci_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            n_reg         <= '0;
            aa_p_reg      <= '0;
            bb_p_reg      <= '0;
            ab_p_reg      <= '0;
            q_reg         <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            cr_reg        <= cr_next;
            ci_reg        <= ci_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            n_reg         <= n_next;
            aa_p_reg      <= aa_p_next;
            bb_p_reg      <= bb_p_next;
            ab_p_reg      <= ab_p_next;
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

// File: src/mbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// port-level checks on the result channel of the escape-time engine
// ----------------------------------------------------------------------------
module mbe_checker
    import mbe_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     result_valid,
    input logic     result_ready,
    input pix_out_t result
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // a point that ran all passes gets full hue
    a_inside_hue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.inside_res && (result.pass_count != '0)
        |-> result.hue == 8'd255)
        else $error("inside point without full hue");

    // an escaped point never reaches full hue
    a_escape_hue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.inside_res |-> result.hue != 8'd255)
        else $error("escaped point with full hue");

    // hue scales the count up, never down, unless the limit is zero
    a_hue_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !(result.inside_res && (result.hue == '0))
        |-> result.hue >= result.pass_count)
        else $error("hue below pass count");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// File: sim/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel
// self-checking bench for the escape-time pixel engine: pixels go in through
// a queue-fed driver, results are scored in order against a bit-exact
// fixed-point escape-time predictor, across many views of the plane
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel;
    import mbe_pkg::*;

    // register values after reset
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_REAL = -32'sd68249547;
    localparam logic signed [COORD_W-1:0] RST_ORIGIN_IMAG = -32'sd45446122;
    localparam logic [STEP_W-1:0]         RST_STEP_REAL   = 31'd1638400;
    localparam logic [STEP_W-1:0]         RST_STEP_IMAG   = 31'd1638400;
    localparam logic [LIMIT_W-1:0]        RST_ITER_LIMIT  = 8'd15;
    localparam logic [STEP_W-1:0]         RST_ESC_LIMIT   = 31'd268435456;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // handy q8.24 values
    localparam logic [CFG_DATA_W-1:0] Q_ONE      = 32'h0100_0000;
    localparam logic [CFG_DATA_W-1:0] Q_FOUR     = 32'h0400_0000;
    localparam logic [CFG_DATA_W-1:0] Q_SIXTEEN  = 32'h1000_0000;
    localparam logic [CFG_DATA_W-1:0] Q_POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] Q_NEG_MAX  = 32'h8000_0000;
    localparam longint                SAT_HI     = 64'sd2147483647;
    localparam longint                SAT_LO     = -64'sd2147483648;

    localparam int RANDOM_PIXELS  = 1100;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_DRAIN      = 600;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_ready;
    pix_in_t               pixel        = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    pix_out_t              result;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // predictor's copy of the registers
    logic signed [COORD_W-1:0] view_real;
    logic signed [COORD_W-1:0] view_imag;
    logic [STEP_W-1:0]         view_step_real;
    logic [STEP_W-1:0]         view_step_imag;
    logic [LIMIT_W-1:0]        view_iter_limit;
    logic [STEP_W-1:0]         view_esc_limit;

    pix_in_t  pending_pixels[$];
    pix_out_t expected_pixels[$];

    int  queued_pixels   = 0;
    int  checked_pixels  = 0;
    int  error_count     = 0;
    int  view_count      = 0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    int  hold_left       = 0;
    int  hold_requests   = 0;
    int  holds_served    = 0;
    int  quiet_cycles    = 0;
    bit  send_idle_on    = 1'b0;
    bit  recv_idle_on    = 1'b0;
    bit  send_busy;
    bit  send_next;
    bit  recv_next;

    mandelbrot_escape_time_pixel i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // clamp to the signed 32 bit range of q8.24
    function automatic longint clamp_q(longint v);
        if (v > SAT_HI)
        begin
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            return SAT_LO;
        end
        return v;
    endfunction

    // escape-time count for one pixel under the current view
    function automatic pix_out_t escape_pixel(pix_in_t px);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      rr;
        longint      ii;
        longint      mag;
        longint      twice_ab;
        int unsigned passes;
        int unsigned shade;
        pix_out_t    res;
        cr = clamp_q(longint'(view_real) + longint'(px.pixel_col) * longint'(view_step_real));
        ci = clamp_q(longint'(view_imag) + longint'(px.pixel_row) * longint'(view_step_imag));
        zr = cr;
        zi = ci;
        passes = 0;
        while (passes < view_iter_limit)
        begin
            // arithmetic shift of the exact product is floor division
            rr  = clamp_q((zr * zr) >>> 24);
            ii  = clamp_q((zi * zi) >>> 24);
            mag = clamp_q(rr + ii);
            if (mag > longint'(view_esc_limit))
            begin
                break;
            end
            twice_ab = clamp_q((zr * zi) >>> 23);
            zi = clamp_q(twice_ab + ci);
            zr = clamp_q(rr - ii + cr);
            passes++;
        end
        // a zero limit runs no pass and has no division
        shade = (view_iter_limit != 0) ? (passes * 255) / view_iter_limit : 0;
        res.out_col    = px.pixel_col;
        res.out_row    = px.pixel_row;
        res.pass_count = passes[LIMIT_W-1:0];
        res.inside_res = (passes == view_iter_limit);
        res.hue        = shade[HUE_W-1:0];
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // pixel driver: takes items from the pending queue, holds each until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
            send_gap    = 0;
        end
        else
        begin
            send_busy = pixel_valid;
            if (pixel_valid && pixel_ready)
            begin
                // registers are stable while items are in flight
                expected_pixels.push_back(escape_pixel(pixel));
                send_busy = 1'b0;
            end
            send_next = send_busy;
            if (!send_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_pixels.size() > 0)
                begin
                    pixel     <= pending_pixels.pop_front();
                    send_next = 1'b1;
                    send_gap  = send_idle_on ? pick_gap() : 0;
                end
            end
            pixel_valid <= send_next;
        end
    end

    // result monitor: scores each item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap     = 0;
            hold_left    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result col %0d row %0d",
                                              result.out_col, result.out_row));
                end
                else
                begin
                    pix_out_t want;
                    want = expected_pixels.pop_front();
                    if (result.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  result.out_col, want.out_col));
                    if (result.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  result.out_row, want.out_row));
                    if (result.pass_count !== want.pass_count)
                        report_mismatch($sformatf("pass_count %0d, want %0d (col %0d row %0d)",
                                                  result.pass_count, want.pass_count,
                                                  want.out_col, want.out_row));
                    if (result.inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res %0b, want %0b (col %0d row %0d)",
                                                  result.inside_res, want.inside_res,
                                                  want.out_col, want.out_row));
                    if (result.hue !== want.hue)
                        report_mismatch($sformatf("hue %0d, want %0d (col %0d row %0d)",
                                                  result.hue, want.hue,
                                                  want.out_col, want.out_row));
                end
                checked_pixels++;
            end
            // a long hold-off lets the engine and its queue fill up
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                recv_next = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                recv_next = 1'b0;
            end
            else
            begin
                recv_next = 1'b1;
                recv_gap  = recv_idle_on ? pick_gap() : 0;
            end
            result_ready <= recv_next;
        end
    end

    // watchdog: too long with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without progress", quiet_cycles);
                $display("tb_mandelbrot_escape_time_pixel: FAIL");
                $finish;
            end
        end
    end

    // one register write, mirrored into the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            REG_ORIGIN_REAL: view_real       = data;
            REG_ORIGIN_IMAG: view_imag       = data;
            REG_STEP_REAL:   view_step_real  = data[STEP_W-1:0];
            REG_STEP_IMAG:   view_step_imag  = data[STEP_W-1:0];
            REG_ITER_LIMIT:  view_iter_limit = data[LIMIT_W-1:0];
            REG_ESC_LIMIT:   view_esc_limit  = data[STEP_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic apply_view(logic [CFG_DATA_W-1:0] org_r, logic [CFG_DATA_W-1:0] org_i,
                              logic [CFG_DATA_W-1:0] stp_r, logic [CFG_DATA_W-1:0] stp_i,
                              logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] esc);
        write_reg(REG_ORIGIN_REAL, org_r);
        write_reg(REG_ORIGIN_IMAG, org_i);
        write_reg(REG_STEP_REAL, stp_r);
        write_reg(REG_STEP_IMAG, stp_i);
        write_reg(REG_ITER_LIMIT, lim);
        write_reg(REG_ESC_LIMIT, esc);
        view_count++;
    endtask

    task automatic add_pixel(int col, int row);
        pix_in_t px;
        px.pixel_col = col[COL_W-1:0];
        px.pixel_row = row[ROW_W-1:0];
        pending_pixels.push_back(px);
        queued_pixels++;
    endtask

    // registers change only once every queued pixel has come back
    task automatic wait_drained();
        wait (checked_pixels == queued_pixels);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] org_r;
        logic [CFG_DATA_W-1:0] org_i;
        logic [CFG_DATA_W-1:0] stp_r;
        logic [CFG_DATA_W-1:0] stp_i;
        logic [CFG_DATA_W-1:0] lim;
        logic [CFG_DATA_W-1:0] esc;
        int kind;
        int count;
        int random_sent;

        view_real       = RST_ORIGIN_REAL;
        view_imag       = RST_ORIGIN_IMAG;
        view_step_real  = RST_STEP_REAL;
        view_step_imag  = RST_STEP_IMAG;
        view_iter_limit = RST_ITER_LIMIT;
        view_esc_limit  = RST_ESC_LIMIT;
        view_count      = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view, frame corners and a few inner points
        add_pixel(0, 0);
        add_pixel(63, 63);
        add_pixel(0, 63);
        add_pixel(63, 0);
        add_pixel(31, 28);
        add_pixel(42, 28);
        wait_drained();

        // writes to unmapped indexes must leave the view alone
        write_reg(REG_SPARE_6, $urandom());
        write_reg(REG_SPARE_7, $urandom());
        add_pixel(42, 27);
        add_pixel(21, 36);
        wait_drained();

        // zero iteration limit: no pass, inside, hue zero
        write_reg(REG_ITER_LIMIT, 32'd0);
        add_pixel(5, 9);
        add_pixel(63, 0);
        wait_drained();

        // saturated c and magnitude with the widest escape bound: never escapes
        apply_view(Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX, Q_POS_MAX, 32'd6, Q_POS_MAX);
        add_pixel(0, 0);
        add_pixel(63, 63);
        add_pixel(63, 0);
        wait_drained();

        // zero escape bound: c at the origin stays, c at one leaves at once
        apply_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd255, 32'd0);
        add_pixel(0, 0);
        wait_drained();
        apply_view(Q_ONE, 32'd0, 32'd0, 32'd0, 32'd255, 32'd0);
        add_pixel(17, 40);
        wait_drained();

        // classic view with the deepest and shallowest limits
        apply_view(32'hFE00_0000, 32'hFE80_0000, 32'h000C_0000, 32'h000C_0000,
                   32'd255, Q_FOUR);
        add_pixel(40, 32);
        add_pixel(10, 20);
        add_pixel(47, 45);
        wait_drained();
        write_reg(REG_ITER_LIMIT, 32'd1);
        add_pixel(40, 32);
        add_pixel(0, 0);
        wait_drained();

        // random views, each with a batch of random pixels
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // wide view from about -2.5 - 1.5i, jittered origin and scale
                org_r = 32'hFD80_0000 + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                org_i = 32'hFE80_0000 + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                stp_r = $urandom_range(32'h0004_0000, 32'h0010_0000);
                stp_i = $urandom_range(32'h0004_0000, 32'h0010_0000);
                esc   = ($urandom_range(0, 1) != 0) ? Q_FOUR : Q_SIXTEEN;
            end
            else if (kind == 6)
            begin
                // deep zoom near the boundary
                org_r = 32'hFF40_0000 + $urandom_range(0, 32'h0001_0000);
                org_i = 32'h0019_9999 + $urandom_range(0, 32'h0001_0000);
                stp_r = $urandom_range(0, 4096);
                stp_i = $urandom_range(0, 4096);
                esc   = Q_FOUR;
            end
            else if (kind == 7)
            begin
                // anything goes, including saturating coordinates
                org_r = $urandom();
                org_i = $urandom();
                stp_r = $urandom();
                stp_i = $urandom();
                esc   = $urandom();
            end
            else
            begin
                // escape bound at one of its extremes
                org_r = 32'hFD80_0000;
                org_i = 32'hFE80_0000;
                stp_r = $urandom_range(0, 32'h0010_0000);
                stp_i = $urandom_range(0, 32'h0010_0000);
                esc   = (kind == 8) ? 32'd0 : ($urandom() | Q_POS_MAX);
            end
            case ($urandom_range(0, 15))
                0:       lim = 32'd0;
                1:       lim = 32'd255;
                2:       lim = 32'd1;
                default: lim = $urandom_range(2, 40);
            endcase
            // upper bits of the limit word must be ignored
            lim = lim | ($urandom() & 32'hFFFF_FF00);
            apply_view(org_r, org_i, stp_r, stp_i, lim, esc);

            count        = (lim[LIMIT_W-1:0] > 64) ? 15 : $urandom_range(60, 120);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (view_count == 8 || $urandom_range(0, 5) == 0)
            begin
                // flood the input while the output is held off
                send_idle_on = 1'b0;
                hold_requests++;
            end
            repeat (count)
            begin
                add_pixel($urandom_range(0, 63), $urandom_range(0, 63));
            end
            random_sent += count;
            wait_drained();
        end

        // last results are in; give the engine time to show any stray item
        wait (checked_pixels == queued_pixels);
        repeat (END_DRAIN) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        end

        $display("summary: %0d pixels scored over %0d register settings, %0d long hold-offs",
                 checked_pixels, view_count, holds_served);
        $display("summary: %0d mismatches", error_count);
        if (error_count == 0)
        begin
            $display("tb_mandelbrot_escape_time_pixel: PASS");
        end
        else
        begin
            $display("tb_mandelbrot_escape_time_pixel: FAIL");
        end
        $finish;
    end

endmodule
